// ----- hdl/upd_pkg.sv -----
// shared types, constants and helper functions for the url percent decoder
// no dependencies

package upd_pkg;

  localparam logic [7:0] PctChar = 8'h25;
  localparam int unsigned DefQueueDepth = 2;
  localparam int unsigned MaxBytes = 3;

  // one decoded input word as a group of output bytes
  typedef struct packed {
    logic [1:0]      cnt;
    logic            last;
    logic [2:0][7:0] bytes;
  } upd_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } upd_qstat_t;

  function automatic logic is_hex(input logic [7:0] c);
    logic r;
    r = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
        ((c >= 8'h41) && (c <= 8'h46));
    return r;
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c - 8'h30;
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      v = c - 8'h57;
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

// ----- hdl/upd_front.sv -----
// front end: accepts raw bytes, tracks the escape state, builds output groups
// depends on upd_pkg

module upd_front
  import upd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  upd_qstat_t qstat_i,
  output logic       push_o,
  output upd_cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhPct   = 2'd1,
    PhDigit = 2'd2
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic       accept;

  logic [1:0]      n;
  logic [2:0][7:0] bytes;

  always_comb begin
    n       = 2'd0;
    bytes   = '0;
    phase_d = PhIdle;
    held_d  = held_q;
    case (phase_q)
      PhPct: begin
        if (is_hex(in_byte_i)) begin
          held_d  = in_byte_i;
          phase_d = PhDigit;
        end else begin
          bytes[n] = PctChar;
          n        = n + 2'd1;
          if (in_byte_i == PctChar) begin
            phase_d = PhPct;
          end else begin
            bytes[n] = in_byte_i;
            n        = n + 2'd1;
          end
        end
      end
      PhDigit: begin
        if (is_hex(in_byte_i)) begin
          bytes[n] = {hex_value(held_q), hex_value(in_byte_i)};
          n        = n + 2'd1;
        end else begin
          // broken escape: percent, the held digit, then rescan this byte
          bytes[n] = PctChar;
          n        = n + 2'd1;
          bytes[n] = held_q;
          n        = n + 2'd1;
          if (in_byte_i == PctChar) begin
            phase_d = PhPct;
          end else begin
            bytes[n] = in_byte_i;
            n        = n + 2'd1;
          end
        end
      end
      default: begin
        if (in_byte_i == PctChar) begin
          phase_d = PhPct;
        end else begin
          bytes[n] = in_byte_i;
          n        = n + 2'd1;
        end
      end
    endcase
    // end of string flushes any pending escape as plain bytes
    if (in_last_i) begin
      if (phase_d == PhPct) begin
        bytes[n] = PctChar;
        n        = n + 2'd1;
      end else if (phase_d == PhDigit) begin
        bytes[n] = PctChar;
        n        = n + 2'd1;
        bytes[n] = held_d;
        n        = n + 2'd1;
      end
      phase_d = PhIdle;
    end
  end

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && (n != 2'd0);

  always_comb begin
    cmd_o.cnt   = n;
    cmd_o.last  = in_last_i;
    cmd_o.bytes = bytes;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      held_q  <= 8'h00;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

// ----- hdl/upd_fifo.sv -----
// short queue of output groups between the front and back ends
// depends on upd_pkg

module upd_fifo
  import upd_pkg::*;
#(
  parameter int unsigned Depth = DefQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  upd_cmd_t   push_data_i,
  input  logic       pop_i,
  output upd_cmd_t   head_o,
  output upd_qstat_t qstat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  upd_cmd_t            mem_q [Depth];
  logic     [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic     [CntW-1:0] count_q;

  always_comb begin
    qstat_o.full  = (count_q == CntW'(Depth));
    qstat_o.empty = (count_q == '0);
  end

  assign head_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat_o.full |-> !push_i || pop_i)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat_o.empty |-> !pop_i)
    else $error("queue read while empty");
`endif

endmodule

// ----- hdl/upd_back.sv -----
// back end: plays out each queued group one byte per word, marks the final byte
// depends on upd_pkg

module upd_back
  import upd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  upd_cmd_t   head_i,
  input  upd_qstat_t qstat_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic [1:0] idx_q;
  logic       final_byte;
  logic       fire;

  assign out_valid_o = !qstat_i.empty;
  assign final_byte  = (idx_q == (head_i.cnt - 2'd1));
  assign out_byte_o  = head_i.bytes[idx_q];
  assign out_last_o  = head_i.last && final_byte;
  assign fire        = out_valid_o && out_ready_i;
  assign pop_o       = fire && final_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (fire) begin
      idx_q <= final_byte ? 2'd0 : idx_q + 2'd1;
    end
  end

`ifndef SYNTH
  a_group_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> head_i.cnt != 2'd0)
    else $error("empty group in queue");
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> idx_q < head_i.cnt)
    else $error("byte index beyond group");
`endif

endmodule

// ----- hdl/url_percent_decoder.sv -----
// top level of the streaming url percent decoder
// depends on upd_pkg, upd_front, upd_fifo, upd_back

// Decodes a percent-encoded string that arrives one byte per word, with tlast
// on the final byte. A '%' with two hex digits (either case) becomes one byte;
// a broken escape passes the '%' and any held digit through and rescans the
// current byte, and at the end of a string any pending '%' and digit are
// flushed, the last output byte carrying tlast. Zero bytes are plain data and
// no terminator is produced. Rate: streams whose inputs each yield zero or one
// output byte run at one byte per cycle while m_axis_tready stays high and
// QueueDepth is above one; an input that yields several bytes holds the single
// output port until all are played out. The front end keeps accepting while
// fewer than QueueDepth groups wait; input stalls only once the queue is full.

module url_percent_decoder
  import upd_pkg::*;
#(
  parameter int unsigned QueueDepth = DefQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // in_last
  // output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // out_last
);

  upd_cmd_t   push_cmd;
  upd_cmd_t   head_cmd;
  upd_qstat_t qstat;
  logic       push;
  logic       pop;

  // front: escape tracking, one word per cycle while the queue is not full
  upd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .qstat_i    (qstat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // queue of decoded groups, registered storage parts the two sides
  upd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .qstat_o     (qstat)
  );

  // back: serializes each group onto the output stream
  upd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
